### hw/rtl/tlfr_pkg.sv
// types, constants and tag tables shared across the frame receiver
`timescale 1ns / 1ps

package tlfr_pkg;

    localparam int unsigned StartTagLen = 13;
    localparam int unsigned SizeTagLen  = 6;
    localparam int unsigned CloseTagLen = 7;
    localparam int unsigned LenBytes    = 4;

    localparam logic [7:0] ChLt    = 8'h3c; // '<'
    localparam logic [7:0] ChG     = 8'h47; // 'G'
    localparam logic [3:0] PosZero = 4'd0;
    localparam logic [3:0] PosOne  = 4'd1;
    localparam logic [3:0] PosTwo  = 4'd2;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_SIZE  = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_CLOSE = 5'b01000,
        PH_DATA  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
        logic       rx_fault;
    } t_in_item;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [1:0]  ack_count;
        logic        header_accepted;
        logic [31:0] declared_size;
        logic        transfer_done;
        logic        fault_abort;
    } t_result;

    // start tag characters
    function automatic logic [7:0] start_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h3c;
            4'd1:    c = 8'h47;
            4'd2:    c = 8'h41;
            4'd3:    c = 8'h4d;
            4'd4:    c = 8'h4d;
            4'd5:    c = 8'h41;
            4'd6:    c = 8'h5f;
            4'd7:    c = 8'h53;
            4'd8:    c = 8'h54;
            4'd9:    c = 8'h41;
            4'd10:   c = 8'h52;
            4'd11:   c = 8'h54;
            4'd12:   c = 8'h3e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "<SIZE>"
    function automatic logic [7:0] size_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h3c;
            4'd1:    c = 8'h53;
            4'd2:    c = 8'h49;
            4'd3:    c = 8'h5a;
            4'd4:    c = 8'h45;
            4'd5:    c = 8'h3e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "</SIZE>"
    function automatic logic [7:0] close_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h3c;
            4'd1:    c = 8'h2f;
            4'd2:    c = 8'h53;
            4'd3:    c = 8'h49;
            4'd4:    c = 8'h5a;
            4'd5:    c = 8'h45;
            4'd6:    c = 8'h3e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // start-tag position to resume from after a mismatch
    function automatic logic [3:0] resume_pos(input logic [3:0] prev, input logic [7:0] b);
        logic [3:0] r;
        if (prev == PosOne && b == ChG) begin
            r = PosTwo;
        end else if (b == ChLt) begin
            r = PosOne;
        end else begin
            r = PosZero;
        end
        return r;
    endfunction

endpackage

### hw/rtl/tlfr_if.sv
// stream interfaces for received words and result words
`timescale 1ns / 1ps

interface tlfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       chunk_end;
    logic       rx_fault;

    modport source (output valid, output rx_byte, output chunk_end, output rx_fault,
                    input ready);
    modport sink   (input valid, input rx_byte, input chunk_end, input rx_fault,
                    output ready);
endinterface

interface tlfr_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [1:0]  ack_count;
    logic        header_accepted;
    logic [31:0] declared_size;
    logic        transfer_done;
    logic        fault_abort;

    modport source (output valid, output payload_valid, output payload_byte,
                    output ack_count, output header_accepted, output declared_size,
                    output transfer_done, output fault_abort, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input ack_count, input header_accepted, input declared_size,
                    input transfer_done, input fault_abort, output ready);
endinterface

### hw/rtl/tlfr_core.sv
// frame parser state and the per-word next-state and result logic
`timescale 1ns / 1ps

module tlfr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  tlfr_pkg::t_in_item i_item,
    output tlfr_pkg::t_result  o_result
);

    tlfr_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_pos, n_pos;
    logic [31:0]      r_exp, n_exp;
    logic [31:0]      r_cnt, n_cnt;
    logic             r_cbip, n_cbip;
    logic             r_acs, n_acs;

    logic             cbip_eff;
    logic [31:0]      cnt_inc;
    logic             data_done;
    logic [7:0]       b;
    logic [3:0]       pos_inc;
    tlfr_pkg::t_result res;

    assign b        = i_item.rx_byte;
    assign pos_inc  = r_pos + 4'd1;
    assign cnt_inc  = r_cnt + 32'd1;
    assign data_done = (cnt_inc >= r_exp);
    assign cbip_eff = r_acs ? (r_phase == tlfr_pkg::PH_DATA) : r_cbip;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_exp   = r_exp;
        n_cnt   = r_cnt;
        n_cbip  = cbip_eff;
        n_acs   = i_item.chunk_end;
        res     = '0;

        if (i_item.rx_fault) begin
            if (r_phase == tlfr_pkg::PH_DATA) begin
                res.fault_abort = 1'b1;
                n_phase = tlfr_pkg::PH_HUNT;
                n_pos   = tlfr_pkg::PosZero;
                n_exp   = '0;
                n_cnt   = '0;
                n_cbip  = 1'b0;
            end
        end else begin
            unique case (r_phase)
                tlfr_pkg::PH_SIZE: begin
                    if (r_pos < 4'(tlfr_pkg::SizeTagLen) && b == tlfr_pkg::size_char(r_pos)) begin
                        if (pos_inc == 4'(tlfr_pkg::SizeTagLen)) begin
                            n_phase = tlfr_pkg::PH_LEN;
                            n_pos   = tlfr_pkg::PosZero;
                            n_exp   = '0;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end else begin
                        n_phase = tlfr_pkg::PH_HUNT;
                        n_pos   = tlfr_pkg::resume_pos(r_pos, b);
                        n_exp   = '0;
                        n_cnt   = '0;
                        n_cbip  = 1'b0;
                    end
                end
                tlfr_pkg::PH_LEN: begin
                    // little-endian length, one byte lane per position
                    unique case (r_pos[1:0])
                        2'd0: n_exp = r_exp | {24'd0, b};
                        2'd1: n_exp = r_exp | {16'd0, b, 8'd0};
                        2'd2: n_exp = r_exp | {8'd0, b, 16'd0};
                        2'd3: n_exp = r_exp | {b, 24'd0};
                        default: n_exp = r_exp;
                    endcase
                    if (r_pos[1:0] == 2'(tlfr_pkg::LenBytes - 1)) begin
                        n_phase = tlfr_pkg::PH_CLOSE;
                        n_pos   = tlfr_pkg::PosZero;
                    end else begin
                        n_pos = {2'd0, r_pos[1:0] + 2'd1};
                    end
                end
                tlfr_pkg::PH_CLOSE: begin
                    if (r_pos < 4'(tlfr_pkg::CloseTagLen) && b == tlfr_pkg::close_char(r_pos)) begin
                        if (pos_inc == 4'(tlfr_pkg::CloseTagLen)) begin
                            res.header_accepted = 1'b1;
                            res.declared_size   = r_exp;
                            n_pos  = tlfr_pkg::PosZero;
                            n_cnt  = '0;
                            n_cbip = 1'b0;
                            if (r_exp == '0) begin
                                // empty payload completes on the header word
                                res.transfer_done = 1'b1;
                                res.ack_count     = 2'd2;
                                n_phase = tlfr_pkg::PH_HUNT;
                                n_exp   = '0;
                            end else begin
                                res.ack_count = 2'd1;
                                n_phase = tlfr_pkg::PH_DATA;
                            end
                        end else begin
                            n_pos = pos_inc;
                        end
                    end else begin
                        n_phase = tlfr_pkg::PH_HUNT;
                        n_pos   = tlfr_pkg::resume_pos(r_pos, b);
                        n_exp   = '0;
                        n_cnt   = '0;
                        n_cbip  = 1'b0;
                    end
                end
                tlfr_pkg::PH_DATA: begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = b;
                    res.ack_count     = 2'(cbip_eff && (data_done || i_item.chunk_end))
                                      + 2'(data_done);
                    res.transfer_done = data_done;
                    if (data_done) begin
                        n_phase = tlfr_pkg::PH_HUNT;
                        n_pos   = tlfr_pkg::PosZero;
                        n_exp   = '0;
                        n_cnt   = '0;
                        n_cbip  = 1'b0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                default: begin
                    // hunting for the start tag
                    if (r_pos < 4'(tlfr_pkg::StartTagLen) && b == tlfr_pkg::start_char(r_pos)) begin
                        if (pos_inc == 4'(tlfr_pkg::StartTagLen)) begin
                            n_phase = tlfr_pkg::PH_SIZE;
                            n_pos   = tlfr_pkg::PosZero;
                        end else begin
                            n_phase = tlfr_pkg::PH_HUNT;
                            n_pos   = pos_inc;
                        end
                    end else begin
                        n_phase = tlfr_pkg::PH_HUNT;
                        n_pos   = tlfr_pkg::resume_pos(r_pos, b);
                        n_exp   = '0;
                        n_cnt   = '0;
                        n_cbip  = 1'b0;
                    end
                end
            endcase
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlfr_pkg::PH_HUNT;
            r_pos   <= tlfr_pkg::PosZero;
            r_exp   <= '0;
            r_cnt   <= '0;
            r_cbip  <= 1'b0;
            r_acs   <= 1'b1;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_exp   <= n_exp;
            r_cnt   <= n_cnt;
            r_cbip  <= n_cbip;
            r_acs   <= n_acs;
        end
    end

endmodule

### hw/rtl/tagged_length_frame_receiver.sv
// top level of the tagged-length frame receiver: input and result registers
`timescale 1ns / 1ps

// channel   modport  words
// i_in      sink     rx_byte, chunk_end, rx_fault
// o_out     source   payload_valid, payload_byte, ack_count, header_accepted,
//                    declared_size, transfer_done, fault_abort
//
// one word in and one result word out per cycle while o_out does not stall; a word passes
// through the input register, then parse logic into the result register
// the parser state advances as a word moves into the result register
// synchronous active-low reset clears the parser to hunting and both stages empty
// a stall on o_out holds the result register, then the input register, then i_in

module tagged_length_frame_receiver (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tlfr_in_if.sink         i_in,
    tlfr_out_if.source      o_out
);

    logic               r_in_valid;
    tlfr_pkg::t_in_item r_in;
    logic               r_out_valid;
    tlfr_pkg::t_result  r_out;
    tlfr_pkg::t_result  core_res;
    logic               advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    tlfr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.rx_byte   <= i_in.rx_byte;
            r_in.chunk_end <= i_in.chunk_end;
            r_in.rx_fault  <= i_in.rx_fault;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.payload_valid   = r_out.payload_valid;
    assign o_out.payload_byte    = r_out.payload_byte;
    assign o_out.ack_count       = r_out.ack_count;
    assign o_out.header_accepted = r_out.header_accepted;
    assign o_out.declared_size   = r_out.declared_size;
    assign o_out.transfer_done   = r_out.transfer_done;
    assign o_out.fault_abort     = r_out.fault_abort;

endmodule
